// ===== src/bfra_pkg.sv =====
package bfra_pkg;

    localparam int DEF_MAX_SEGMENTS = 64;
    localparam int DEF_ADDR_BITS    = 32;
    localparam int PORT_ADDR_W      = 32;
    localparam int COUNT_W          = 7;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef struct packed {
        op_t                    op;
        logic [PORT_ADDR_W-1:0] addr;
        logic [PORT_ADDR_W-1:0] size;
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_MOVE,
        ST_AWR_SPLIT,
        ST_AWR_PICK,
        ST_FSUM,
        ST_FWR,
        ST_DONE
    } state_t;

endpackage

// ===== src/bfra_front.sv =====
module bfra_front
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  logic [1:0]                       req_type,
    input  logic [bfra_pkg::PORT_ADDR_W-1:0] region_address,
    input  logic [bfra_pkg::PORT_ADDR_W-1:0] request_size,
    output logic                             q_valid,
    output bfra_pkg::req_t                   q_head,
    input  logic                             q_pop
);

    bfra_pkg::req_t q_data_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     fill_reg;
    logic [1:0]     fill_next;
    logic           push;
    logic           pop;
    bfra_pkg::req_t req_in;

    assign req_stall = (fill_reg == 2'd2);
    assign push      = req_valid && !req_stall;
    assign q_valid   = (fill_reg != 2'd0);
    assign pop       = q_pop && q_valid;
    assign q_head    = q_data_reg[rd_ptr_reg];

    always_comb
    begin
        req_in.op   = bfra_pkg::op_t'(req_type);
        req_in.addr = region_address;
        req_in.size = request_size;
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_data_reg[wr_ptr_reg] <= req_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ===== src/bfra_back.sv =====
module bfra_back
#(
    parameter int MAX_SEGMENTS = bfra_pkg::DEF_MAX_SEGMENTS,
    parameter int ADDR_BITS    = bfra_pkg::DEF_ADDR_BITS
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_valid,
    input  bfra_pkg::req_t                   q_head,
    output logic                             q_pop,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output logic                             status,
    output logic [bfra_pkg::PORT_ADDR_W-1:0] granted_address,
    output logic [bfra_pkg::COUNT_W-1:0]     segment_count
);

    localparam int A  = ADDR_BITS;
    localparam int EW = 2 * A + 1;
    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_SEGMENTS);

    logic [EW-1:0] mem [MAX_SEGMENTS];
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    logic [EW-1:0] mem_wd;
    logic          mem_re;
    logic [IW-1:0] mem_ra;
    logic [EW-1:0] rd_data_reg;

    bfra_pkg::state_t state_reg, state_next;
    bfra_pkg::op_t    op_reg, op_next;
    logic [A-1:0]  addr_reg, addr_next;
    logic [A-1:0]  want_reg, want_next;
    logic [CW-1:0] total_reg, total_next;
    logic [CW-1:0] sc_idx_reg, sc_idx_next;
    logic          rv_reg, rv_next;
    logic [CW-1:0] rv_idx_reg, rv_idx_next;
    logic          found_reg, found_next;
    logic [CW-1:0] fi_reg, fi_next;
    logic [EW-1:0] best_reg, best_next;
    logic [EW-1:0] prev_reg, prev_next;
    logic [EW-1:0] nxt_reg, nxt_next;
    logic [EW-1:0] last_reg, last_next;
    logic          pf_reg, pf_next;
    logic          nf_reg, nf_next;
    logic [A-1:0]  acc_reg, acc_next;
    logic [CW-1:0] mv_src_reg, mv_src_next;
    logic [CW-1:0] mv_dst_reg, mv_dst_next;
    logic [CW-1:0] mv_left_reg, mv_left_next;
    logic          mv_down_reg, mv_down_next;
    logic          pend_reg, pend_next;
    logic [IW-1:0] pend_dst_reg, pend_dst_next;
    logic [1:0]    drop_reg, drop_next;
    logic          st_reg, st_next;
    logic [A-1:0]  gr_reg, gr_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_status_reg, out_status_next;
    logic [A-1:0]  out_gr_reg, out_gr_next;
    logic [CW-1:0] out_cnt_reg, out_cnt_next;

    logic [A-1:0]  q_addr;
    logic [A-1:0]  q_size;
    logic [A-1:0]  e_start;
    logic [A-1:0]  e_size;
    logic          e_free;
    logic [A-1:0]  b_start;
    logic [A-1:0]  b_size;
    logic          scan_more;
    logic          out_free;

    assign q_addr  = A'(q_head.addr);
    assign q_size  = A'(q_head.size);
    assign e_start = rd_data_reg[EW-1:A+1];
    assign e_size  = rd_data_reg[A:1];
    assign e_free  = rd_data_reg[0];
    assign b_start = best_reg[EW-1:A+1];
    assign b_size  = best_reg[A:1];
    assign scan_more = (sc_idx_reg < total_reg);
    assign out_free  = !out_valid_reg || !rsp_stall;

    assign rsp_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign granted_address = bfra_pkg::PORT_ADDR_W'(out_gr_reg);
    assign segment_count   = bfra_pkg::COUNT_W'(out_cnt_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bfra_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_head.op == bfra_pkg::OP_ALLOC || q_head.op == bfra_pkg::OP_FREE)
                    begin
                        state_next = bfra_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = bfra_pkg::ST_DONE;
                    end
                end
            end
            bfra_pkg::ST_SCAN:
            begin
                if (!scan_more && !rv_reg)
                begin
                    state_next = bfra_pkg::ST_DECIDE;
                end
            end
            bfra_pkg::ST_DECIDE:
            begin
                if (op_reg == bfra_pkg::OP_ALLOC)
                begin
                    if (!found_reg || want_reg == '0 || b_size == want_reg
                        || total_reg == MAXC)
                    begin
                        state_next = bfra_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = bfra_pkg::ST_MOVE;
                    end
                end
                else
                begin
                    state_next = found_reg ? bfra_pkg::ST_FSUM : bfra_pkg::ST_DONE;
                end
            end
            bfra_pkg::ST_FSUM:      state_next = bfra_pkg::ST_FWR;
            bfra_pkg::ST_FWR:       state_next = bfra_pkg::ST_MOVE;
            bfra_pkg::ST_MOVE:
            begin
                if (mv_left_reg == '0 && !pend_reg)
                begin
                    state_next = (op_reg == bfra_pkg::OP_ALLOC) ? bfra_pkg::ST_AWR_SPLIT
                                                               : bfra_pkg::ST_DONE;
                end
            end
            bfra_pkg::ST_AWR_SPLIT: state_next = bfra_pkg::ST_AWR_PICK;
            bfra_pkg::ST_AWR_PICK:  state_next = bfra_pkg::ST_DONE;
            bfra_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = bfra_pkg::ST_IDLE;
                end
            end
            default:                state_next = bfra_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        op_next       = op_reg;
        addr_next     = addr_reg;
        want_next     = want_reg;
        total_next    = total_reg;
        sc_idx_next   = sc_idx_reg;
        rv_next       = 1'b0;
        rv_idx_next   = rv_idx_reg;
        found_next    = found_reg;
        fi_next       = fi_reg;
        best_next     = best_reg;
        prev_next     = prev_reg;
        nxt_next      = nxt_reg;
        last_next     = last_reg;
        pf_next       = pf_reg;
        nf_next       = nf_reg;
        acc_next      = acc_reg;
        mv_src_next   = mv_src_reg;
        mv_dst_next   = mv_dst_reg;
        mv_left_next  = mv_left_reg;
        mv_down_next  = mv_down_reg;
        pend_next     = 1'b0;
        pend_dst_next = pend_dst_reg;
        drop_next     = drop_reg;
        st_next       = st_reg;
        gr_next       = gr_reg;
        q_pop         = 1'b0;
        mem_we        = 1'b0;
        mem_wa        = '0;
        mem_wd        = '0;
        mem_re        = 1'b0;
        mem_ra        = '0;
        out_valid_next  = out_valid_reg && rsp_stall;
        out_status_next = out_status_reg;
        out_gr_next     = out_gr_reg;
        out_cnt_next    = out_cnt_reg;

        case (state_reg)
            bfra_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop       = 1'b1;
                    op_next     = q_head.op;
                    addr_next   = q_addr;
                    want_next   = q_size;
                    st_next     = 1'b1;
                    gr_next     = '0;
                    sc_idx_next = '0;
                    found_next  = 1'b0;
                    case (q_head.op)
                        bfra_pkg::OP_INIT:
                        begin
                            if (q_size != '0)
                            begin
                                mem_we     = 1'b1;
                                mem_wa     = '0;
                                mem_wd     = {q_addr, q_size, 1'b1};
                                total_next = CW'(1);
                                st_next    = 1'b0;
                            end
                        end
                        bfra_pkg::OP_CLEAR:
                        begin
                            total_next = '0;
                            st_next    = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            bfra_pkg::ST_SCAN:
            begin
                if (scan_more)
                begin
                    mem_re      = 1'b1;
                    mem_ra      = sc_idx_reg[IW-1:0];
                    rv_next     = 1'b1;
                    rv_idx_next = sc_idx_reg;
                    sc_idx_next = sc_idx_reg + CW'(1);
                end
                if (rv_reg)
                begin
                    last_next = rd_data_reg;
                    if (op_reg == bfra_pkg::OP_ALLOC)
                    begin
                        if (e_free && e_size >= want_reg && (!found_reg || e_size < b_size))
                        begin
                            found_next = 1'b1;
                            fi_next    = rv_idx_reg;
                            best_next  = rd_data_reg;
                        end
                    end
                    else
                    begin
                        if (!found_reg && e_start == addr_reg)
                        begin
                            found_next = 1'b1;
                            fi_next    = rv_idx_reg;
                            best_next  = rd_data_reg;
                            prev_next  = last_reg;
                        end
                        else if (found_reg && rv_idx_reg == fi_reg + CW'(1))
                        begin
                            nxt_next = rd_data_reg;
                        end
                    end
                end
            end
            bfra_pkg::ST_DECIDE:
            begin
                if (op_reg == bfra_pkg::OP_ALLOC)
                begin
                    if (found_reg && want_reg != '0)
                    begin
                        if (b_size == want_reg)
                        begin
                            mem_we  = 1'b1;
                            mem_wa  = fi_reg[IW-1:0];
                            mem_wd  = {b_start, b_size, 1'b0};
                            gr_next = b_start;
                            st_next = 1'b0;
                        end
                        else if (total_reg != MAXC)
                        begin
                            mv_dst_next  = total_reg;
                            mv_src_next  = total_reg - CW'(1);
                            mv_left_next = total_reg - fi_reg - CW'(1);
                            mv_down_next = 1'b1;
                        end
                    end
                end
                else if (found_reg)
                begin
                    pf_next = (fi_reg != '0) && prev_reg[0];
                    nf_next = (fi_reg + CW'(1) < total_reg) && nxt_reg[0];
                end
            end
            bfra_pkg::ST_FSUM:
            begin
                acc_next = pf_reg ? prev_reg[A:1] + b_size : b_size + nxt_reg[A:1];
            end
            bfra_pkg::ST_FWR:
            begin
                mem_we       = 1'b1;
                mv_down_next = 1'b0;
                mv_dst_next  = fi_reg;
                if (pf_reg && nf_reg)
                begin
                    mem_wa       = IW'(fi_reg - CW'(1));
                    mem_wd       = {prev_reg[EW-1:A+1], acc_reg + nxt_reg[A:1], 1'b1};
                    mv_src_next  = fi_reg + CW'(2);
                    mv_left_next = total_reg - fi_reg - CW'(2);
                    drop_next    = 2'd2;
                end
                else if (pf_reg)
                begin
                    mem_wa       = IW'(fi_reg - CW'(1));
                    mem_wd       = {prev_reg[EW-1:A+1], acc_reg, 1'b1};
                    mv_src_next  = fi_reg + CW'(1);
                    mv_left_next = total_reg - fi_reg - CW'(1);
                    drop_next    = 2'd1;
                end
                else if (nf_reg)
                begin
                    mem_wa       = fi_reg[IW-1:0];
                    mem_wd       = {b_start, acc_reg, 1'b1};
                    mv_dst_next  = fi_reg + CW'(1);
                    mv_src_next  = fi_reg + CW'(2);
                    mv_left_next = total_reg - fi_reg - CW'(2);
                    drop_next    = 2'd1;
                end
                else
                begin
                    mem_wa       = fi_reg[IW-1:0];
                    mem_wd       = {b_start, b_size, 1'b1};
                    mv_left_next = '0;
                    drop_next    = 2'd0;
                end
            end
            bfra_pkg::ST_MOVE:
            begin
                if (pend_reg)
                begin
                    mem_we = 1'b1;
                    mem_wa = pend_dst_reg;
                    mem_wd = rd_data_reg;
                end
                if (mv_left_reg != '0)
                begin
                    mem_re        = 1'b1;
                    mem_ra        = mv_src_reg[IW-1:0];
                    pend_next     = 1'b1;
                    pend_dst_next = mv_dst_reg[IW-1:0];
                    mv_left_next  = mv_left_reg - CW'(1);
                    mv_src_next   = mv_down_reg ? mv_src_reg - CW'(1) : mv_src_reg + CW'(1);
                    mv_dst_next   = mv_down_reg ? mv_dst_reg - CW'(1) : mv_dst_reg + CW'(1);
                end
                else if (!pend_reg && op_reg == bfra_pkg::OP_FREE)
                begin
                    total_next = total_reg - CW'(drop_reg);
                    st_next    = 1'b0;
                end
            end
            bfra_pkg::ST_AWR_SPLIT:
            begin
                mem_we = 1'b1;
                mem_wa = IW'(fi_reg + CW'(1));
                mem_wd = {b_start + want_reg, b_size - want_reg, 1'b1};
            end
            bfra_pkg::ST_AWR_PICK:
            begin
                mem_we     = 1'b1;
                mem_wa     = fi_reg[IW-1:0];
                mem_wd     = {b_start, want_reg, 1'b0};
                total_next = total_reg + CW'(1);
                gr_next    = b_start;
                st_next    = 1'b0;
            end
            bfra_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = st_reg;
                    out_gr_next     = st_reg ? '0 : gr_reg;
                    out_cnt_next    = total_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        addr_reg        <= addr_next;
        want_reg        <= want_next;
        sc_idx_reg      <= sc_idx_next;
        rv_idx_reg      <= rv_idx_next;
        fi_reg          <= fi_next;
        best_reg        <= best_next;
        prev_reg        <= prev_next;
        nxt_reg         <= nxt_next;
        last_reg        <= last_next;
        pf_reg          <= pf_next;
        nf_reg          <= nf_next;
        acc_reg         <= acc_next;
        mv_src_reg      <= mv_src_next;
        mv_dst_reg      <= mv_dst_next;
        mv_down_reg     <= mv_down_next;
        pend_dst_reg    <= pend_dst_next;
        drop_reg        <= drop_next;
        st_reg          <= st_next;
        gr_reg          <= gr_next;
        out_status_reg  <= out_status_next;
        out_gr_reg      <= out_gr_next;
        out_cnt_reg     <= out_cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfra_pkg::ST_IDLE;
            total_reg     <= '0;
            rv_reg        <= 1'b0;
            found_reg     <= 1'b0;
            mv_left_reg   <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            rv_reg        <= rv_next;
            found_reg     <= found_next;
            mv_left_reg   <= mv_left_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= MAXC)
        else $error("segment total above table size");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg |-> out_gr_reg == '0)
        else $error("failed item carries an address");

    a_pend_in_move: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> state_reg == bfra_pkg::ST_MOVE)
        else $error("pending move write outside move sweep");

    a_split_room: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bfra_pkg::ST_AWR_PICK |-> total_reg < MAXC)
        else $error("split with full table");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == bfra_pkg::ST_IDLE && q_valid)
        else $error("queue pop while busy");

endmodule

// ===== src/best_fit_region_allocator_top.sv =====
// Best-fit region allocator. Each item is one request (init, allocate, free,
// clear) and yields exactly one result item with a status, the granted start
// address and the segment count. Allocate and free scan the segment table
// through one memory with a registered read, one entry a cycle, then, where
// needed, shift entries to make or close a gap, one entry a cycle. A two-item
// input queue takes new requests while one is being worked on.
module best_fit_region_allocator_top
#(
    parameter int MAX_SEGMENTS = bfra_pkg::DEF_MAX_SEGMENTS,
    parameter int ADDR_BITS    = bfra_pkg::DEF_ADDR_BITS
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  logic [1:0]                       req_type,
    input  logic [bfra_pkg::PORT_ADDR_W-1:0] region_address,
    input  logic [bfra_pkg::PORT_ADDR_W-1:0] request_size,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output logic                             status,
    output logic [bfra_pkg::PORT_ADDR_W-1:0] granted_address,
    output logic [bfra_pkg::COUNT_W-1:0]     segment_count
);

    logic           q_valid;
    bfra_pkg::req_t q_head;
    logic           q_pop;

    bfra_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req_type       (req_type),
        .region_address (region_address),
        .request_size   (request_size),
        .q_valid        (q_valid),
        .q_head         (q_head),
        .q_pop          (q_pop)
    );

    bfra_back
    #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .ADDR_BITS    (ADDR_BITS)
    )
    u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_head          (q_head),
        .q_pop           (q_pop),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .status          (status),
        .granted_address (granted_address),
        .segment_count   (segment_count)
    );

endmodule
